// ===== rtl/tcgc_pkg.sv =====
package tcgc_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam int CH_COUNT = 3;
    localparam logic [1:0] CH_LAST = 2'(CH_COUNT - 1);

    localparam int MIX_STEPS = 9;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_LINEAR = 2'd1,
        KIND_MATRIX = 2'd2,
        KIND_NONE   = 2'd3
    } t_zone_kind;

    typedef enum logic [2:0] {
        REG_START_COLOR = 3'd0,
        REG_END_COLOR   = 3'd1,
        REG_SPEED       = 3'd2,
        REG_FRAME_RATE  = 3'd3,
        REG_ZONE_KIND   = 3'd4,
        REG_SPAN        = 3'd5,
        REG_START_INDEX = 3'd6,
        REG_REVERSE     = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_FOLD,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [23:0] start_color;
        logic [23:0] end_color;
        logic [4:0]  speed;
        logic [7:0]  frame_rate;
        logic [1:0]  zone_kind;
        logic [10:0] span;
        logic [9:0]  start_index;
        logic        reverse;
    } t_cfg;

    typedef struct packed {
        logic       cmd;
        logic [9:0] position;
        logic [9:0] map_led;
    } t_in_item;

    typedef struct packed {
        logic [10:0] led_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_out_item;

    localparam logic [23:0] RST_START_COLOR = 24'hFF0000;
    localparam logic [23:0] RST_END_COLOR   = 24'h0000FF;
    localparam logic [4:0]  RST_SPEED       = 5'd10;
    localparam logic [7:0]  RST_FRAME_RATE  = 8'd60;
    localparam logic [1:0]  RST_ZONE_KIND   = 2'd1;
    localparam logic [10:0] RST_SPAN        = 11'd1;
    localparam logic [9:0]  RST_START_INDEX = 10'd0;
    localparam logic        RST_REVERSE     = 1'b0;

endpackage

// ===== rtl/two_color_gradient_cycler.sv =====
// Tick item: one restoring divide of the phase step, or only a phase clear at the wrap.
// Pixel item: accept, fold, then per channel a multiply, 9 divide steps and a collect,
// then one output load.
// Items for zone kind 3 are taken and dropped; a full output register holds the sequencer.
// Synchronous active-low reset: phase cleared, registers to defaults, no item pending.
module two_color_gradient_cycler #(
    parameter int MAX_SPAN  = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  tcgc_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tcgc_pkg::t_out_item          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcgc_pkg::APB_AW-1:0]  paddr,
    input  logic [tcgc_pkg::APB_DW-1:0]  pwdata,
    output logic [tcgc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import tcgc_pkg::*;

    localparam int PMAX       = (MAX_SPAN > 255) ? MAX_SPAN : 255;
    localparam int PPW        = $clog2(PMAX + 1);
    localparam int DW         = PPW + FRAC_BITS;
    localparam int PHW        = $clog2(2 * PMAX + 32) + FRAC_BITS;
    localparam int VW         = PHW + 1;
    localparam int NW         = VW + 8;
    localparam int QW         = FRAC_BITS + 5;
    localparam int CNTW       = $clog2(QW + 1);
    localparam int TICK_STEPS = FRAC_BITS + 5;
    localparam logic [PHW:0] PHASE_LIM = (PHW + 1)'(64'(2 * PMAX + 32) << FRAC_BITS);

    t_cfg cfg;

    tcgc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic            div_start;
    logic [CNTW-1:0] div_steps;
    logic [NW-1:0]   div_num;
    logic [NW-1:0]   div_dsh;
    logic            div_busy;
    logic [QW-1:0]   div_quot;
    logic            div_rem_nz;

    tcgc_div #(
        .NW   (NW),
        .QW   (QW),
        .CNTW (CNTW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_steps  (div_steps),
        .i_num    (div_num),
        .i_dsh    (div_dsh),
        .o_busy   (div_busy),
        .o_quot   (div_quot),
        .o_rem_nz (div_rem_nz)
    );

    t_state          r_state, n_state;
    logic [PHW-1:0]  r_phase, n_phase;
    logic [VW-1:0]   r_v, n_v;
    logic [DW-1:0]   r_d, n_d;
    logic [VW-1:0]   r_g, n_g;
    logic [10:0]     r_idx, n_idx;
    logic [1:0]      r_ch, n_ch;
    logic [7:0]      r_red, n_red;
    logic [7:0]      r_green, n_green;
    logic [7:0]      r_blue, n_blue;
    t_out_item       r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic [7:0]      rate_eff;
    logic [31:0]     span_eff;
    logic [PPW-1:0]  period;
    logic [DW-1:0]   d_cur;
    logic [10:0]     idx_cur;
    logic [VW-1:0]   v_cur;
    logic [VW-1:0]   d_ext, d2_ext;
    logic [7:0]      ch_s, ch_e, ch_abs;
    logic            ch_neg;
    logic [8:0]      q9;
    logic [8:0]      sum_pos, q_ceil;
    logic [7:0]      ch_val;

    assign rate_eff = (cfg.frame_rate == 8'd0) ? 8'd1 : cfg.frame_rate;
    assign span_eff = (cfg.span == 11'd0) ? 32'd1 :
                      ((32'(cfg.span) > 32'(MAX_SPAN)) ? 32'(MAX_SPAN) : 32'(cfg.span));
    assign period   = (cfg.zone_kind == KIND_SINGLE) ? PPW'(rate_eff) : PPW'(span_eff);
    assign d_cur    = {period, {FRAC_BITS{1'b0}}};

    always_comb begin
        if (cfg.zone_kind == KIND_MATRIX) begin
            idx_cur = {1'b0, cfg.start_index} + {1'b0, i_in_data.map_led};
        end else if (cfg.reverse) begin
            idx_cur = {1'b0, cfg.start_index} + span_eff[10:0] - 11'd1
                      - {1'b0, i_in_data.position};
        end else begin
            idx_cur = {1'b0, cfg.start_index} + {1'b0, i_in_data.position};
        end
    end

    assign v_cur = (cfg.zone_kind == KIND_SINGLE) ? VW'(r_phase) :
                   VW'(r_phase) + (VW'(i_in_data.position) << FRAC_BITS);

    assign d_ext  = VW'(r_d);
    assign d2_ext = d_ext << 1;

    always_comb begin
        unique case (r_ch)
            2'd0: begin
                ch_s = cfg.start_color[23:16];
                ch_e = cfg.end_color[23:16];
            end
            2'd1: begin
                ch_s = cfg.start_color[15:8];
                ch_e = cfg.end_color[15:8];
            end
            default: begin
                ch_s = cfg.start_color[7:0];
                ch_e = cfg.end_color[7:0];
            end
        endcase
    end

    assign ch_neg  = (ch_e < ch_s);
    assign ch_abs  = ch_neg ? (ch_s - ch_e) : (ch_e - ch_s);
    assign q9      = div_quot[8:0];
    assign sum_pos = {1'b0, ch_s} + {1'b0, q9[7:0]};
    assign q_ceil  = {1'b0, q9[7:0]} + {8'd0, div_rem_nz};

    always_comb begin
        if (!ch_neg) begin
            ch_val = (q9[8] || sum_pos[8]) ? 8'd255 : sum_pos[7:0];
        end else begin
            ch_val = (q9[8] || (q_ceil > {1'b0, ch_s})) ? 8'd0 : (ch_s - q_ceil[7:0]);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_v         = r_v;
        n_d         = r_d;
        n_g         = r_g;
        n_idx       = r_idx;
        n_ch        = r_ch;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;
        div_steps   = CNTW'(MIX_STEPS);
        div_num     = '0;
        div_dsh     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && (cfg.zone_kind != KIND_NONE)) begin
                    if (i_in_data.cmd == CMD_TICK) begin
                        if (VW'(r_phase) >= (VW'(d_cur) << 1)) begin
                            n_phase = '0;
                        end else begin
                            div_start = 1'b1;
                            div_steps = CNTW'(TICK_STEPS);
                            div_num   = NW'(cfg.speed) << FRAC_BITS;
                            div_dsh   = NW'(rate_eff) << (TICK_STEPS - 1);
                            n_state   = S_TICK;
                        end
                    end else begin
                        n_v     = v_cur;
                        n_d     = d_cur;
                        n_idx   = idx_cur;
                        n_state = S_FOLD;
                    end
                end
            end
            S_TICK: begin
                if (!div_busy) begin
                    n_phase = PHW'(VW'(r_phase) + VW'(div_quot));
                    n_state = S_IDLE;
                end
            end
            S_FOLD: begin
                if (r_v <= d_ext) begin
                    n_g = r_v;
                end else if (r_v <= d2_ext) begin
                    n_g = d2_ext - r_v;
                end else begin
                    n_g = r_v - d2_ext;
                end
                n_ch    = 2'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                div_start = 1'b1;
                div_steps = CNTW'(MIX_STEPS);
                div_num   = NW'(r_g) * NW'(ch_abs);
                div_dsh   = NW'(r_d) << 8;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (!div_busy) begin
                    unique case (r_ch)
                        2'd0:    n_red   = ch_val;
                        2'd1:    n_green = ch_val;
                        default: n_blue  = ch_val;
                    endcase
                    if (r_ch == CH_LAST) begin
                        n_state = S_OUT;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.led_index = r_idx;
                    n_out.red       = r_red;
                    n_out.green     = r_green;
                    n_out.blue      = r_blue;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_ch        <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
        r_v     <= n_v;
        r_d     <= n_d;
        r_g     <= n_g;
        r_idx   <= n_idx;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_out   <= n_out;
    end

`ifndef SYNTHESIS
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_TICK || r_state == S_DIV))
        else $error("divider busy outside a divide state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result shown without passing the output state");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch <= CH_LAST)
        else $error("channel counter out of range");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_phase} < PHASE_LIM)
        else $error("phase beyond its wrap bound");
`endif

endmodule

// ===== rtl/tcgc_regs.sv =====
module tcgc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcgc_pkg::APB_AW-1:0]  paddr,
    input  logic [tcgc_pkg::APB_DW-1:0]  pwdata,
    output logic [tcgc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output tcgc_pkg::t_cfg               o_cfg
);
    import tcgc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_color <= RST_START_COLOR;
            r_cfg.end_color   <= RST_END_COLOR;
            r_cfg.speed       <= RST_SPEED;
            r_cfg.frame_rate  <= RST_FRAME_RATE;
            r_cfg.zone_kind   <= RST_ZONE_KIND;
            r_cfg.span        <= RST_SPAN;
            r_cfg.start_index <= RST_START_INDEX;
            r_cfg.reverse     <= RST_REVERSE;
        end else if (wr_en) begin
            unique case (idx)
                REG_START_COLOR: r_cfg.start_color <= pwdata[23:0];
                REG_END_COLOR:   r_cfg.end_color   <= pwdata[23:0];
                REG_SPEED:       r_cfg.speed       <= pwdata[4:0];
                REG_FRAME_RATE:  r_cfg.frame_rate  <= pwdata[7:0];
                REG_ZONE_KIND:   r_cfg.zone_kind   <= pwdata[1:0];
                REG_SPAN:        r_cfg.span        <= pwdata[10:0];
                REG_START_INDEX: r_cfg.start_index <= pwdata[9:0];
                REG_REVERSE:     r_cfg.reverse     <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_START_COLOR: prdata = APB_DW'(r_cfg.start_color);
            REG_END_COLOR:   prdata = APB_DW'(r_cfg.end_color);
            REG_SPEED:       prdata = APB_DW'(r_cfg.speed);
            REG_FRAME_RATE:  prdata = APB_DW'(r_cfg.frame_rate);
            REG_ZONE_KIND:   prdata = APB_DW'(r_cfg.zone_kind);
            REG_SPAN:        prdata = APB_DW'(r_cfg.span);
            REG_START_INDEX: prdata = APB_DW'(r_cfg.start_index);
            REG_REVERSE:     prdata = APB_DW'(r_cfg.reverse);
        endcase
    end

endmodule

// ===== rtl/tcgc_div.sv =====
module tcgc_div #(
    parameter int NW   = 29,
    parameter int QW   = 13,
    parameter int CNTW = $clog2(QW + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [CNTW-1:0] i_steps,
    input  logic [NW-1:0]   i_num,
    input  logic [NW-1:0]   i_dsh,
    output logic            o_busy,
    output logic [QW-1:0]   o_quot,
    output logic            o_rem_nz
);
    logic [NW-1:0]   r_rem, n_rem;
    logic [NW-1:0]   r_dsh, n_dsh;
    logic [QW-1:0]   r_quot, n_quot;
    logic [CNTW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_rem  = i_num;
            n_dsh  = i_dsh;
            n_quot = '0;
            n_cnt  = i_steps;
        end else if (r_cnt != '0) begin
            if (r_rem >= r_dsh) begin
                n_rem  = r_rem - r_dsh;
                n_quot = {r_quot[QW-2:0], 1'b1};
            end else begin
                n_quot = {r_quot[QW-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_busy   = (r_cnt != '0);
    assign o_quot   = r_quot;
    assign o_rem_nz = |r_rem;

endmodule

// ===== test/two_color_gradient_cycler_test.sv =====
module two_color_gradient_cycler_test;
    import tcgc_pkg::*;

    localparam int MAX_SPAN    = 1024;
    localparam int FRAC_BITS   = 8;
    localparam int SETTLE      = 48;
    localparam int HOLD_OFF    = 400;
    localparam int WATCHDOG    = 2000;
    localparam int PHASE_ITEMS = 70;

    class color_scoreboard;
        t_cfg        regs;
        longint      phase;
        t_out_item   pending_leds[$];
        int unsigned errors;

        function new();
            regs = '{start_color: RST_START_COLOR, end_color: RST_END_COLOR,
                     speed: RST_SPEED, frame_rate: RST_FRAME_RATE,
                     zone_kind: RST_ZONE_KIND, span: RST_SPAN,
                     start_index: RST_START_INDEX, reverse: RST_REVERSE};
            phase = 0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_START_COLOR: regs.start_color = value[23:0];
                REG_END_COLOR:   regs.end_color   = value[23:0];
                REG_SPEED:       regs.speed       = value[4:0];
                REG_FRAME_RATE:  regs.frame_rate  = value[7:0];
                REG_ZONE_KIND:   regs.zone_kind   = value[1:0];
                REG_SPAN:        regs.span        = value[10:0];
                REG_START_INDEX: regs.start_index = value[9:0];
                REG_REVERSE:     regs.reverse     = value[0];
                default: ;
            endcase
        endfunction

        function longint zone_span();
            if (regs.span == 0) return 1;
            if (regs.span > MAX_SPAN) return MAX_SPAN;
            return longint'(regs.span);
        endfunction

        function logic [7:0] blend(logic [7:0] s, logic [7:0] e, longint g, longint d);
            longint c;
            c = (longint'(s) * d + g * (longint'(e) - longint'(s))) / d;
            if (c < 0) return 8'd0;
            if (c > 255) return 8'd255;
            return 8'(c);
        endfunction

        function void note_item(t_in_item it);
            longint    rate;
            longint    d;
            longint    v;
            longint    g;
            longint    idx;
            t_out_item led;
            if (regs.zone_kind == KIND_NONE) return;
            rate = (regs.frame_rate == 0) ? 64'sd1 : longint'(regs.frame_rate);
            d = ((regs.zone_kind == KIND_SINGLE) ? rate : zone_span()) << FRAC_BITS;
            if (it.cmd == CMD_TICK) begin
                if (phase < 2 * d) phase += (longint'(regs.speed) << FRAC_BITS) / rate;
                else phase = 0;
                return;
            end
            v = phase;
            if (regs.zone_kind != KIND_SINGLE) v += longint'(it.position) << FRAC_BITS;
            g = (v > d) ? 2 * d - v : v;
            if (g < 0) g = -g;
            if (regs.zone_kind == KIND_MATRIX) begin
                idx = longint'(regs.start_index) + longint'(it.map_led);
            end else if (regs.reverse) begin
                idx = longint'(regs.start_index) + zone_span() - 1 - longint'(it.position);
            end else begin
                idx = longint'(regs.start_index) + longint'(it.position);
            end
            led.led_index = 11'(idx);
            led.red   = blend(regs.start_color[23:16], regs.end_color[23:16], g, d);
            led.green = blend(regs.start_color[15:8], regs.end_color[15:8], g, d);
            led.blue  = blend(regs.start_color[7:0], regs.end_color[7:0], g, d);
            pending_leds.insert(pending_leds.size(), led);
        endfunction

        function void check_led(t_out_item got);
            t_out_item want;
            if (pending_leds.size() == 0) begin
                $error("unexpected led item: led_index %0d", got.led_index);
                errors++;
                return;
            end
            want = pending_leds.pop_front();
            if (got.led_index !== want.led_index) begin
                $error("led_index: expected %0d, actual %0d", want.led_index, got.led_index);
                errors++;
            end
            if (got.red !== want.red) begin
                $error("red: expected %0d, actual %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, actual %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int unsigned       holds_asked = 0;
    int unsigned       quiet_cycles = 0;
    color_scoreboard   sb = new();

    two_color_gradient_cycler dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_item(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_led(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("two_color_gradient_cycler_test: done, errors");
            $finish;
        end
    end

    initial begin : receiver
        int unsigned mode;
        int unsigned left;
        int unsigned hold;
        int unsigned holds_done;
        mode = 0;
        left = 0;
        hold = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (holds_done != holds_asked) begin
                holds_done++;
                hold = HOLD_OFF;
                i_out_ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_item(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic pixel(int pos, int map);
        send_item(t_in_item'{cmd: CMD_PIXEL, position: 10'(pos), map_led: 10'(map)});
    endtask

    task automatic tick();
        send_item(t_in_item'{cmd: CMD_TICK, position: 10'h3FF, map_led: 10'h3FF});
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_leds.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic configure(t_cfg c);
        drain();
        apb_write(REG_START_COLOR, 32'(c.start_color));
        apb_write(REG_END_COLOR, 32'(c.end_color));
        apb_write(REG_SPEED, 32'(c.speed));
        apb_write(REG_FRAME_RATE, 32'(c.frame_rate));
        apb_write(REG_ZONE_KIND, 32'(c.zone_kind));
        apb_write(REG_SPAN, 32'(c.span));
        apb_write(REG_START_INDEX, 32'(c.start_index));
        apb_write(REG_REVERSE, 32'(c.reverse));
    endtask

    function automatic logic [31:0] edgy(int w);
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return (32'd1 << w) - 1;
            default: return $urandom & ((32'd1 << w) - 1);
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cfg        c;
        int unsigned k;
        c.start_color = 24'(edgy(24));
        c.end_color   = 24'(edgy(24));
        c.speed       = 5'(edgy(5));
        c.frame_rate  = 8'(edgy(8));
        c.span        = ($urandom_range(0, 3) == 0) ? 11'(edgy(11)) : 11'($urandom_range(1, 40));
        c.start_index = 10'(edgy(10));
        c.reverse     = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 9);
        c.zone_kind   = (k == 9) ? KIND_NONE : 2'(k / 3);
        return c;
    endfunction

    function automatic t_in_item random_item(t_cfg c);
        t_in_item    it;
        int unsigned lim;
        lim = (c.span == 0) ? 1 : ((c.span > MAX_SPAN) ? MAX_SPAN : c.span);
        it.cmd      = ($urandom_range(0, 99) < 35) ? CMD_TICK : CMD_PIXEL;
        it.position = $urandom_range(0, 1) ? 10'($urandom_range(0, lim - 1))
                                           : 10'($urandom_range(0, 1023));
        it.map_led  = 10'($urandom_range(0, 1023));
        return it;
    endfunction

    task automatic send_items(t_cfg c, int n);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n; i++) begin
                send_item(random_item(c));
                sent++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin : main
        t_cfg c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        pixel(0, 0);
        pixel(1023, 1023);
        tick();
        pixel(3, 0);

        configure('{start_color: 24'h000000, end_color: 24'hFFFFFF, speed: 5'd31,
                    frame_rate: 8'd0, zone_kind: KIND_SINGLE, span: 11'd0,
                    start_index: 10'd1023, reverse: 1'b1});
        pixel(0, 0);
        tick();
        pixel(1023, 5);
        tick();
        pixel(7, 0);

        configure('{start_color: 24'hFFFFFF, end_color: 24'h000000, speed: 5'd0,
                    frame_rate: 8'd255, zone_kind: KIND_LINEAR, span: 11'd2047,
                    start_index: 10'd0, reverse: 1'b1});
        pixel(1023, 0);
        pixel(0, 0);
        tick();
        pixel(512, 0);

        configure('{start_color: 24'h123456, end_color: 24'hFEDCBA, speed: 5'd17,
                    frame_rate: 8'd3, zone_kind: KIND_LINEAR, span: 11'd1,
                    start_index: 10'd0, reverse: 1'b1});
        pixel(5, 0);
        tick();
        pixel(1023, 0);

        configure('{start_color: 24'h00FF80, end_color: 24'hFF0040, speed: 5'd31,
                    frame_rate: 8'd1, zone_kind: KIND_MATRIX, span: 11'd64,
                    start_index: 10'd1023, reverse: 1'b1});
        pixel(1023, 1023);
        tick();
        pixel(0, 0);
        pixel(40, 512);

        configure('{start_color: 24'hABCDEF, end_color: 24'h000000, speed: 5'd5,
                    frame_rate: 8'd9, zone_kind: KIND_NONE, span: 11'd8,
                    start_index: 10'd10, reverse: 1'b0});
        tick();
        pixel(3, 3);

        c = '{start_color: 24'hFFFFFF, end_color: 24'h000000, speed: 5'd31,
              frame_rate: 8'd255, zone_kind: KIND_MATRIX, span: 11'd2047,
              start_index: 10'd1023, reverse: 1'b1};
        configure(c);
        holds_asked++;
        send_items(c, PHASE_ITEMS);

        c = '{start_color: 24'h000000, end_color: 24'h000000, speed: 5'd0,
              frame_rate: 8'd0, zone_kind: KIND_SINGLE, span: 11'd0,
              start_index: 10'd0, reverse: 1'b0};
        configure(c);
        send_items(c, PHASE_ITEMS);

        for (int k = 0; k < 8; k++) begin
            c = random_config();
            configure(c);
            send_items(c, (c.zone_kind == KIND_NONE) ? 15 : PHASE_ITEMS);
        end

        drain();
        if (sb.errors == 0)
            $display("two_color_gradient_cycler_test: done, clean");
        else
            $display("two_color_gradient_cycler_test: done, errors");
        $finish;
    end

endmodule
